// File: rtl/emr_pkg.sv
// shared constants and types of the midpoint ellipse rasterizer
package emr_pkg;

   // default axis length width and center coordinate width
   localparam int AXIS_BITS_DEF  = 9;
   localparam int COORD_BITS_DEF = 10;

   // decision value width, two's complement, wraps
   localparam int DEC_BITS = 48;

   // width of every result coordinate
   localparam int OUT_BITS = 12;

   // scale applied to a product before it is accumulated
   typedef enum logic [1:0] {
      SCALE_1 = 2'd0,
      SCALE_4 = 2'd1,
      SCALE_8 = 2'd2
   } acc_scale_type;

   // one accumulator operation
   typedef struct packed {
      logic          en;
      logic          clr;
      logic          sub;
      acc_scale_type scale;
   } acc_op_type;

   // one result word
   typedef struct packed {
      logic                point_valid;
      logic [OUT_BITS-1:0] right_x;
      logic [OUT_BITS-1:0] left_x;
      logic [OUT_BITS-1:0] lower_y;
      logic [OUT_BITS-1:0] upper_y;
      logic                last_set;
   } result_type;

endpackage

// File: rtl/emr_mul.sv
// shared multiplier with registered product
module emr_mul #(
   parameter int A_BITS = 29,
   parameter int B_BITS = 11
) (
   input  logic                     clock,
   input  logic [A_BITS-1:0]        op_a,
   input  logic [B_BITS-1:0]        op_b,
   output logic [A_BITS+B_BITS-1:0] prod_ff
);

   // one product per cycle
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

// File: rtl/emr_accum.sv
// decision value accumulator: clear, add or subtract a scaled product
module emr_accum (
   input  logic                        clock,
   input  logic                        reset,
   input  emr_pkg::acc_op_type         op,
   input  logic [emr_pkg::DEC_BITS-1:0] term,
   output logic [emr_pkg::DEC_BITS-1:0] acc_ff
);

   logic [emr_pkg::DEC_BITS-1:0] scaled;
   logic [emr_pkg::DEC_BITS-1:0] base;
   logic [emr_pkg::DEC_BITS-1:0] acc_in;

   // scale the product by a power of two
   always_comb begin
      unique case (op.scale)
         emr_pkg::SCALE_4: scaled = term << 2;
         emr_pkg::SCALE_8: scaled = term << 3;
         default:          scaled = term;
      endcase
   end

   // add or subtract onto the old value or onto zero
   always_comb begin
      base   = op.clr ? '0 : acc_ff;
      acc_in = op.sub ? base - scaled : base + scaled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (op.en) begin
         acc_ff <= acc_in;
      end
   end

endmodule

// File: rtl/emr_seq.sv
// sequencer: ellipse state, operand selection and result forming
module emr_seq #(
   parameter int AXIS_BITS  = emr_pkg::AXIS_BITS_DEF,
   parameter int COORD_BITS = emr_pkg::COORD_BITS_DEF,
   parameter int MA_BITS    = 3 * AXIS_BITS + 2,
   parameter int MB_BITS    = AXIS_BITS + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          mode,
   input  logic [COORD_BITS-1:0]         center_x,
   input  logic [COORD_BITS-1:0]         center_y,
   input  logic [AXIS_BITS-1:0]          semi_axis_a,
   input  logic [AXIS_BITS-1:0]          semi_axis_b,
   input  logic                          out_free,
   input  logic [MA_BITS+MB_BITS-1:0]    prod,
   input  logic [emr_pkg::DEC_BITS-1:0]  acc,
   output logic [MA_BITS-1:0]            mul_a,
   output logic [MB_BITS-1:0]            mul_b,
   output emr_pkg::acc_op_type           acc_op,
   output logic                          ready,
   output logic                          res_fire,
   output emr_pkg::result_type           result
);

   localparam int OB_BITS = AXIS_BITS + 1;
   localparam int SB_BITS = 2 * AXIS_BITS;
   localparam logic MODE_START = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_AA,
      ST_BB,
      ST_AB,
      ST_ASUB,
      ST_AADD,
      ST_R1_BX,
      ST_R1_AY,
      ST_R1_B1,
      ST_R1_FIN,
      ST_H_BTX,
      ST_H_BTX2,
      ST_H_ATY,
      ST_H_ATY2,
      ST_H_AB,
      ST_H_AB2,
      ST_H_FIN,
      ST_R2_AY,
      ST_R2_A1,
      ST_R2_AADD,
      ST_R2_BX,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [OB_BITS-1:0]    x_ff;
   logic [OB_BITS-1:0]    y_ff;
   logic [COORD_BITS-1:0] cx_ff;
   logic [COORD_BITS-1:0] cy_ff;
   logic [AXIS_BITS-1:0]  a_ff;
   logic [AXIS_BITS-1:0]  b_ff;
   logic [SB_BITS-1:0]    a2_ff;
   logic [SB_BITS-1:0]    b2_ff;
   logic [MA_BITS-1:0]    cmp_ff;
   logic                  over_ff;
   logic                  diag_ff;
   logic                  region_two_ff;
   logic                  active_ff;
   logic                  null_ff;

   logic                  dec_neg;
   logic                  dec_pos;
   logic [MB_BITS-1:0]    tx;
   logic [OB_BITS-1:0]    ty;
   logic [MA_BITS-1:0]    prod_lo;

   // decision sign tests and handover operands
   always_comb begin
      dec_neg = acc[emr_pkg::DEC_BITS-1];
      dec_pos = (acc != '0) && !dec_neg;
      tx      = {x_ff, 1'b1};
      ty      = (y_ff != '0) ? y_ff - OB_BITS'(1) : '0;
      prod_lo = prod[MA_BITS-1:0];
   end

   // operand selection and accumulator control per step
   always_comb begin
      mul_a        = '0;
      mul_b        = '0;
      acc_op.en    = 1'b0;
      acc_op.clr   = 1'b0;
      acc_op.sub   = 1'b0;
      acc_op.scale = emr_pkg::SCALE_1;
      unique case (state_ff)
         ST_AA: begin
            mul_a = MA_BITS'(a_ff);
            mul_b = MB_BITS'(a_ff);
         end
         ST_BB: begin
            mul_a = MA_BITS'(b_ff);
            mul_b = MB_BITS'(b_ff);
         end
         ST_AB: begin
            mul_a        = MA_BITS'(a2_ff);
            mul_b        = MB_BITS'(b_ff);
            acc_op.en    = 1'b1;
            acc_op.clr   = 1'b1;
            acc_op.scale = emr_pkg::SCALE_4;
         end
         ST_ASUB: begin
            mul_a        = MA_BITS'(a2_ff);
            mul_b        = MB_BITS'(1);
            acc_op.en    = 1'b1;
            acc_op.sub   = 1'b1;
            acc_op.scale = emr_pkg::SCALE_4;
         end
         ST_AADD: begin
            acc_op.en = 1'b1;
         end
         ST_R1_BX: begin
            mul_a = MA_BITS'(b2_ff);
            mul_b = MB_BITS'(x_ff);
         end
         ST_R1_AY: begin
            mul_a        = MA_BITS'(a2_ff);
            mul_b        = MB_BITS'(y_ff);
            acc_op.en    = 1'b1;
            acc_op.scale = emr_pkg::SCALE_8;
         end
         ST_R1_B1: begin
            mul_a        = MA_BITS'(b2_ff);
            mul_b        = MB_BITS'(1);
            acc_op.en    = diag_ff;
            acc_op.sub   = 1'b1;
            acc_op.scale = emr_pkg::SCALE_8;
         end
         ST_R1_FIN: begin
            acc_op.en    = 1'b1;
            acc_op.scale = emr_pkg::SCALE_4;
         end
         ST_H_BTX: begin
            mul_a = MA_BITS'(b2_ff);
            mul_b = tx;
         end
         ST_H_BTX2: begin
            mul_a = prod_lo;
            mul_b = tx;
         end
         ST_H_ATY: begin
            mul_a      = MA_BITS'(a2_ff);
            mul_b      = MB_BITS'(ty);
            acc_op.en  = 1'b1;
            acc_op.clr = 1'b1;
         end
         ST_H_ATY2: begin
            mul_a = prod_lo;
            mul_b = MB_BITS'(ty);
         end
         ST_H_AB: begin
            mul_a        = MA_BITS'(a2_ff);
            mul_b        = MB_BITS'(b_ff);
            acc_op.en    = 1'b1;
            acc_op.scale = emr_pkg::SCALE_4;
         end
         ST_H_AB2: begin
            mul_a = prod_lo;
            mul_b = MB_BITS'(b_ff);
         end
         ST_H_FIN: begin
            acc_op.en    = 1'b1;
            acc_op.sub   = 1'b1;
            acc_op.scale = emr_pkg::SCALE_4;
         end
         ST_R2_AY: begin
            mul_a = MA_BITS'(a2_ff);
            mul_b = MB_BITS'(y_ff);
         end
         ST_R2_A1: begin
            mul_a        = MA_BITS'(a2_ff);
            mul_b        = MB_BITS'(1);
            acc_op.en    = 1'b1;
            acc_op.sub   = 1'b1;
            acc_op.scale = emr_pkg::SCALE_8;
         end
         ST_R2_AADD: begin
            mul_a        = MA_BITS'(b2_ff);
            mul_b        = MB_BITS'(x_ff);
            acc_op.en    = 1'b1;
            acc_op.scale = emr_pkg::SCALE_4;
         end
         ST_R2_BX: begin
            acc_op.en    = 1'b1;
            acc_op.scale = emr_pkg::SCALE_8;
         end
         default: begin
         end
      endcase
   end

   // result word from the latched center and current offsets
   always_comb begin
      ready    = (state_ff == ST_IDLE);
      res_fire = (state_ff == ST_EMIT) && out_free;
      if (null_ff) begin
         result = '0;
      end else begin
         result.point_valid = 1'b1;
         result.right_x = emr_pkg::OUT_BITS'(cx_ff) + emr_pkg::OUT_BITS'(x_ff);
         result.left_x  = emr_pkg::OUT_BITS'(cx_ff) - emr_pkg::OUT_BITS'(x_ff);
         result.lower_y = emr_pkg::OUT_BITS'(cy_ff) + emr_pkg::OUT_BITS'(y_ff);
         result.upper_y = emr_pkg::OUT_BITS'(cy_ff) - emr_pkg::OUT_BITS'(y_ff);
         result.last_set = (y_ff == '0);
      end
   end

   // state and ellipse registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         x_ff          <= '0;
         y_ff          <= '0;
         cx_ff         <= '0;
         cy_ff         <= '0;
         a_ff          <= '0;
         b_ff          <= '0;
         a2_ff         <= '0;
         b2_ff         <= '0;
         cmp_ff        <= '0;
         over_ff       <= 1'b0;
         diag_ff       <= 1'b0;
         region_two_ff <= 1'b0;
         active_ff     <= 1'b0;
         null_ff       <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  null_ff <= 1'b0;
                  priority if (mode == MODE_START) begin
                     cx_ff         <= center_x;
                     cy_ff         <= center_y;
                     a_ff          <= semi_axis_a;
                     b_ff          <= semi_axis_b;
                     x_ff          <= '0;
                     y_ff          <= OB_BITS'(semi_axis_b);
                     region_two_ff <= 1'b0;
                     active_ff     <= 1'b1;
                     state_ff      <= ST_AA;
                  end else if (!active_ff) begin
                     null_ff  <= 1'b1;
                     state_ff <= ST_EMIT;
                  end else if (!region_two_ff) begin
                     // region one: x always steps, y on a non-negative decision
                     x_ff    <= x_ff + OB_BITS'(1);
                     diag_ff <= !dec_neg;
                     if (!dec_neg) begin
                        y_ff <= y_ff - OB_BITS'(1);
                     end
                     state_ff <= ST_R1_BX;
                  end else begin
                     // region two: y always steps, x on a non-positive decision
                     y_ff    <= y_ff - OB_BITS'(1);
                     diag_ff <= !dec_pos;
                     if (!dec_pos) begin
                        x_ff <= x_ff + OB_BITS'(1);
                     end
                     state_ff <= ST_R2_AY;
                  end
               end
            end
            ST_AA:      state_ff <= ST_BB;
            ST_BB: begin
               a2_ff    <= prod[SB_BITS-1:0];
               state_ff <= ST_AB;
            end
            ST_AB: begin
               b2_ff    <= prod[SB_BITS-1:0];
               state_ff <= ST_ASUB;
            end
            ST_ASUB:    state_ff <= ST_AADD;
            ST_AADD:    state_ff <= ST_EMIT;
            ST_R1_BX:   state_ff <= ST_R1_AY;
            ST_R1_AY: begin
               cmp_ff   <= prod_lo;
               state_ff <= ST_R1_B1;
            end
            ST_R1_B1: begin
               over_ff  <= (cmp_ff > prod_lo);
               state_ff <= ST_R1_FIN;
            end
            ST_R1_FIN:  state_ff <= over_ff ? ST_H_BTX : ST_EMIT;
            ST_H_BTX:   state_ff <= ST_H_BTX2;
            ST_H_BTX2:  state_ff <= ST_H_ATY;
            ST_H_ATY:   state_ff <= ST_H_ATY2;
            ST_H_ATY2:  state_ff <= ST_H_AB;
            ST_H_AB:    state_ff <= ST_H_AB2;
            ST_H_AB2:   state_ff <= ST_H_FIN;
            ST_H_FIN: begin
               region_two_ff <= 1'b1;
               state_ff      <= ST_EMIT;
            end
            ST_R2_AY:   state_ff <= ST_R2_A1;
            ST_R2_A1:   state_ff <= ST_R2_AADD;
            ST_R2_AADD: state_ff <= diag_ff ? ST_R2_BX : ST_EMIT;
            ST_R2_BX:   state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (out_free) begin
                  if (!null_ff && (y_ff == '0)) begin
                     active_ff <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default:    state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/midpoint_ellipse_rasterizer_core.sv
// top level of the midpoint ellipse rasterizer
//
// usage: the req channel carries one word per command. tuser is the mode:
// 0 starts an ellipse from the center and semi-axes in tdata, 1 advances
// the running ellipse by one point. every accepted word yields exactly one
// rsp word: tuser set when it carries a four-quadrant point set, tlast set
// on the final set (y offset zero). a step with no ellipse running gives a
// word with tuser clear and zero data.
// rate: one word is worked on at a time; all products come from a single
// registered multiplier, one per cycle, feeding a 48-bit accumulator.
// a region-one step that hands over to region two also runs the handover
// states before its result. the result sits in an output register, so the
// next word is taken while it waits.
// reset clears the sequencer and leaves no ellipse running. when rsp is
// stalled the finished word waits in its register; a second result then
// holds the sequencer until the register frees up.
module midpoint_ellipse_rasterizer_core #(
   parameter int AXIS_BITS  = emr_pkg::AXIS_BITS_DEF,
   parameter int COORD_BITS = emr_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // center_x, center_y, semi_axis_a, semi_axis_b, zero padding
   input  logic [((2*COORD_BITS+2*AXIS_BITS+7)/8)*8-1:0] req_tdata,
   // mode
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // right_x, left_x, lower_y, upper_y
   output logic [4*emr_pkg::OUT_BITS-1:0] rsp_tdata,
   // point_valid
   output logic rsp_tuser,
   output logic rsp_tlast
);

   localparam int MA_BITS = 3 * AXIS_BITS + 2;
   localparam int MB_BITS = AXIS_BITS + 2;

   logic                         start;
   logic                         out_free;
   logic                         res_fire;
   logic [MA_BITS-1:0]           mul_a;
   logic [MB_BITS-1:0]           mul_b;
   logic [MA_BITS+MB_BITS-1:0]   prod;
   logic [emr_pkg::DEC_BITS-1:0] acc;
   emr_pkg::acc_op_type          acc_op;
   emr_pkg::result_type          result;
   emr_pkg::result_type          rsp_ff;
   logic                         rsp_valid_ff;

   // handshake
   always_comb begin
      start    = req_tvalid && req_tready;
      out_free = !rsp_valid_ff || rsp_tready;
   end

   emr_seq #(
      .AXIS_BITS  (AXIS_BITS),
      .COORD_BITS (COORD_BITS),
      .MA_BITS    (MA_BITS),
      .MB_BITS    (MB_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .mode        (req_tuser),
      .center_x    (req_tdata[COORD_BITS-1:0]),
      .center_y    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .semi_axis_a (req_tdata[2*COORD_BITS+AXIS_BITS-1:2*COORD_BITS]),
      .semi_axis_b (req_tdata[2*COORD_BITS+2*AXIS_BITS-1:2*COORD_BITS+AXIS_BITS]),
      .out_free    (out_free),
      .prod        (prod),
      .acc         (acc),
      .mul_a       (mul_a),
      .mul_b       (mul_b),
      .acc_op      (acc_op),
      .ready       (req_tready),
      .res_fire    (res_fire),
      .result      (result)
   );

   emr_mul #(
      .A_BITS (MA_BITS),
      .B_BITS (MB_BITS)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   emr_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .op     (acc_op),
      .term   (emr_pkg::DEC_BITS'(prod)),
      .acc_ff (acc)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_fire) begin
         rsp_ff <= result;
      end
   end

   // result word onto the ports
   always_comb begin
      rsp_tvalid = rsp_valid_ff;
      rsp_tuser  = rsp_ff.point_valid;
      rsp_tlast  = rsp_ff.last_set;
      rsp_tdata  = {rsp_ff.upper_y, rsp_ff.lower_y, rsp_ff.left_x, rsp_ff.right_x};
   end

   // a result is loaded only into a free output register
   a_fire_free: assert property (@(posedge clock) disable iff (reset)
      res_fire |-> out_free)
      else $error("result loaded over a waiting word");

   // an accepted word takes the sequencer out of idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("ready stayed high after accept");

   // the last set is always a real point set
   a_last_is_point: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("last flag on an empty word");

   // an empty word carries no coordinates
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata == '0))
      else $error("empty word with nonzero data");

endmodule

// File: sim/emr_point_set_checker.sv
`timescale 1ns / 100ps
// checker of the ellipse rasterizer: predicts every point set and compares result words
module emr_point_set_checker #(
   parameter int AXIS_BITS  = emr_pkg::AXIS_BITS_DEF,
   parameter int COORD_BITS = emr_pkg::COORD_BITS_DEF,
   parameter int REQ_BITS   = ((2*COORD_BITS+2*AXIS_BITS+7)/8)*8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   // center_x, center_y, semi_axis_a, semi_axis_b, zero padding
   input  logic [REQ_BITS-1:0]           req_tdata,
   // mode
   input  logic                          req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // right_x, left_x, lower_y, upper_y
   input  logic [4*emr_pkg::OUT_BITS-1:0] rsp_tdata,
   // point_valid
   input  logic                          rsp_tuser,
   input  logic                          rsp_tlast,
   output int                            mismatch_count,
   output int                            sets_pending
);

   localparam int OUT_BITS = emr_pkg::OUT_BITS;
   localparam int DEC_BITS = emr_pkg::DEC_BITS;
   localparam logic [63:0] OFFS_MASK = (64'd1 << (AXIS_BITS+1)) - 64'd1;

   // rasterizer state as seen by the predictor
   logic [COORD_BITS-1:0] ctr_x;
   logic [COORD_BITS-1:0] ctr_y;
   logic [63:0]           a_sq;
   logic [63:0]           b_sq;
   logic [63:0]           off_x;
   logic [63:0]           off_y;
   logic [DEC_BITS-1:0]   decision;
   logic                  region_two;
   logic                  running;

   emr_pkg::result_type expected_sets[$];
   int                  fail_tally = 0;
   int                  pending_count = 0;

   assign mismatch_count = fail_tally;
   assign sets_pending   = pending_count;

   // works out the point set for one command word and moves the state on
   function automatic emr_pkg::result_type next_point_set(input logic advance,
                                                          input logic [REQ_BITS-1:0] word);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] d;
      logic [63:0] tx;
      logic [63:0] ty;
      emr_pkg::result_type r;
      r = '0;
      d = {{(64-DEC_BITS){1'b0}}, decision};
      if (!advance) begin
         // start: latch the ellipse and open region one at the top
         a = 64'(word[2*COORD_BITS +: AXIS_BITS]);
         b = 64'(word[2*COORD_BITS+AXIS_BITS +: AXIS_BITS]);
         ctr_x = word[0 +: COORD_BITS];
         ctr_y = word[COORD_BITS +: COORD_BITS];
         a_sq = a * a;
         b_sq = b * b;
         off_x = '0;
         off_y = b;
         region_two = 1'b0;
         running = 1'b1;
         d = 4 * b_sq - 4 * a_sq * b + a_sq;
         decision = d[DEC_BITS-1:0];
      end else if (!running) begin
         // step with nothing running gives an empty word
         return r;
      end else if (!region_two) begin
         // region one steps in x, y drops when the decision is not negative
         off_x = (off_x + 64'd1) & OFFS_MASK;
         if (d[DEC_BITS-1]) begin
            d = d + 8 * b_sq * off_x + 4 * b_sq;
         end else begin
            off_y = off_y - 64'd1;
            d = d + 8 * b_sq * off_x - 8 * a_sq * off_y + 4 * b_sq;
         end
         decision = d[DEC_BITS-1:0];
         // hand over once the slope passes minus one
         if (b_sq * off_x > a_sq * off_y) begin
            tx = 2 * off_x + 64'd1;
            ty = (off_y > 0) ? off_y - 64'd1 : 64'd0;
            d = b_sq * tx * tx + 4 * a_sq * ty * ty - 4 * a_sq * b_sq;
            region_two = 1'b1;
            decision = d[DEC_BITS-1:0];
         end
      end else begin
         // region two steps in y, x grows when the decision is not positive
         off_y = off_y - 64'd1;
         if (d[DEC_BITS-1:0] != '0 && !d[DEC_BITS-1]) begin
            d = d + 4 * a_sq - 8 * a_sq * off_y;
         end else begin
            off_x = (off_x + 64'd1) & OFFS_MASK;
            d = d + 8 * b_sq * off_x - 8 * a_sq * off_y + 4 * a_sq;
         end
         decision = d[DEC_BITS-1:0];
      end
      // mirror into the four quadrants
      r.point_valid = 1'b1;
      r.right_x = OUT_BITS'(64'(ctr_x) + off_x);
      r.left_x  = OUT_BITS'(64'(ctr_x) - off_x);
      r.lower_y = OUT_BITS'(64'(ctr_y) + off_y);
      r.upper_y = OUT_BITS'(64'(ctr_y) - off_y);
      r.last_set = (off_y == 0);
      if (off_y == 0) running = 1'b0;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [OUT_BITS-1:0] want,
                              input logic [OUT_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_tally++;
      end
   endtask

   // follow both channels, predict on accepted commands, compare on results
   always @(posedge clock) begin
      emr_pkg::result_type seen;
      emr_pkg::result_type want;
      if (reset) begin
         ctr_x = '0;
         ctr_y = '0;
         a_sq = '0;
         b_sq = '0;
         off_x = '0;
         off_y = '0;
         decision = '0;
         region_two = 1'b0;
         running = 1'b0;
         expected_sets.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_sets.push_back(next_point_set(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            seen.point_valid = rsp_tuser;
            seen.right_x = rsp_tdata[0 +: OUT_BITS];
            seen.left_x = rsp_tdata[OUT_BITS +: OUT_BITS];
            seen.lower_y = rsp_tdata[2*OUT_BITS +: OUT_BITS];
            seen.upper_y = rsp_tdata[3*OUT_BITS +: OUT_BITS];
            seen.last_set = rsp_tlast;
            if (expected_sets.size() == 0) begin
               $error("result word with no command waiting for it");
               fail_tally++;
            end else begin
               want = expected_sets.pop_front();
               check_field("point_valid", OUT_BITS'(want.point_valid),
                           OUT_BITS'(seen.point_valid));
               check_field("right_x", want.right_x, seen.right_x);
               check_field("left_x", want.left_x, seen.left_x);
               check_field("lower_y", want.lower_y, seen.lower_y);
               check_field("upper_y", want.upper_y, seen.upper_y);
               check_field("last_set", OUT_BITS'(want.last_set), OUT_BITS'(seen.last_set));
            end
         end
      end
      pending_count <= expected_sets.size();
   end

endmodule

// File: sim/tb_midpoint_ellipse_rasterizer_core.sv
`timescale 1ns / 100ps
// testbench top of the ellipse rasterizer: stimulus, output stalls, watchdog and verdict
module tb_midpoint_ellipse_rasterizer_core;

   localparam int   CRD_BITS    = emr_pkg::COORD_BITS_DEF;
   localparam int   AX_BITS     = emr_pkg::AXIS_BITS_DEF;
   localparam int   OUT_BITS    = emr_pkg::OUT_BITS;
   localparam int   REQ_BITS    = ((2*CRD_BITS+2*AX_BITS+7)/8)*8;
   localparam logic MODE_START  = 1'b0;
   localparam logic MODE_STEP   = 1'b1;
   localparam int   RANDOM_WORDS = 1000;
   localparam int   LONG_HOLD   = 300;
   localparam int   STALL_LIMIT = 2000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_BITS-1:0]   req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [4*OUT_BITS-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   int   mismatch_count;
   int   sets_pending;
   int   starts_sent = 0;
   int   steps_sent = 0;
   int   results_seen = 0;
   int   idle_cycles = 0;
   int   gap_pct = 0;
   int   stall_pct = 0;
   logic quiet_tail = 1'b0;
   logic long_hold_req = 1'b0;

   midpoint_ellipse_rasterizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   emr_point_set_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .sets_pending   (sets_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0: pick_pct = 0;
         1: pick_pct = 10;
         default: pick_pct = 40;
      endcase
   endfunction

   // offer one command word, maybe after an idle burst, and wait for it to be taken
   task automatic send_word(input logic mode, input logic [CRD_BITS-1:0] cx,
                            input logic [CRD_BITS-1:0] cy,
                            input logic [AX_BITS-1:0] a,
                            input logic [AX_BITS-1:0] b);
      if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= REQ_BITS'({b, a, cy, cx});
      do @(posedge clock); while (!req_tready);
      if (mode == MODE_START) starts_sent++;
      else steps_sent++;
   endtask

   task automatic start_ellipse(input int cx, input int cy, input int a, input int b);
      send_word(MODE_START, CRD_BITS'(cx), CRD_BITS'(cy), AX_BITS'(a), AX_BITS'(b));
   endtask

   // step words carry random filler in the unused fields
   task automatic step_ellipse(input int count);
      repeat (count)
         send_word(MODE_STEP, CRD_BITS'($urandom), CRD_BITS'($urandom),
                   AX_BITS'($urandom), AX_BITS'($urandom));
   endtask

   // main stimulus
   initial begin
      int kind;
      int a;
      int b;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= MODE_START;
      req_tdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle step, unit circle at the origin corner, largest ellipse
      // at the far corner abandoned by a flat start, vertical line, and a flat
      // ellipse that reaches y zero while still in region one
      gap_pct = 20;
      step_ellipse(1);
      start_ellipse(0, 0, 1, 1);
      step_ellipse(3);
      start_ellipse(1023, 1023, 511, 511);
      step_ellipse(2);
      start_ellipse(512, 3, 5, 0);
      step_ellipse(1);
      start_ellipse(7, 1000, 0, 3);
      step_ellipse(4);
      start_ellipse(20, 0, 6, 1);
      step_ellipse(7);

      // random: mostly whole small ellipses, some large ones cut short, some noise
      while (starts_sent + steps_sent < RANDOM_WORDS + 25) begin
         if (starts_sent + steps_sent > 300 && steps_sent < 400 && !long_hold_req)
            long_hold_req = 1'b1;
         if (starts_sent + steps_sent > RANDOM_WORDS - 130) quiet_tail = 1'b1;
         gap_pct = pick_pct();
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            a = $urandom_range(1, 24);
            b = $urandom_range(1, 24);
            start_ellipse($urandom_range(0, 1023), $urandom_range(0, 1023), a, b);
            step_ellipse(a + b + $urandom_range(0, 2));
         end else if (kind < 9) begin
            start_ellipse($urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 511), $urandom_range(0, 511));
            step_ellipse($urandom_range(0, 30));
         end else begin
            repeat ($urandom_range(1, 4))
               send_word(1'($urandom_range(0, 1)), CRD_BITS'($urandom),
                         CRD_BITS'($urandom), AX_BITS'($urandom), AX_BITS'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      // drain, then idle on for stray words before the verdict
      while (sets_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d start words and %0d step words, %0d result words compared",
               starts_sent, steps_sent, results_seen);
      $display("included axis extremes, zero axes, abandoned runs and a %0d-cycle rsp stall",
               LONG_HOLD);
      if (mismatch_count == 0 && sets_pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // receiver: random stall bursts, long hold-offs when the stimulus asks, none near the end
   initial begin
      rsp_tready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold_req === 1'b1 && stall_pct >= 0) begin
            long_hold_req = 1'b0;
            stall_pct = -1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            stall_pct = 0;
         end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
         if ($urandom_range(0, 63) == 0 && stall_pct >= 0) stall_pct = pick_pct();
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) results_seen++;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
